@@ hdl/l2lb_pkg.sv @@
// Package for the learning bridge forwarder: widths, codes and state types.
// No dependencies; the forwarder and the checker use it by scoped names.
package l2lb_pkg;

  localparam int NumPorts   = 8;
  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int PortW      = 3;
  localparam int MacW       = 48;
  localparam int VlanW      = 12;
  localparam int KeyW       = VlanW + MacW;
  localparam int EntryW     = 1 + KeyW + PortW;
  localparam int CfgW       = 48;
  localparam int GroupBit   = 40;

  localparam logic [1:0] CfgValidMask = 2'd0;
  localparam logic [1:0] CfgVlanLow   = 2'd1;
  localparam logic [1:0] CfgVlanHigh  = 2'd2;

  localparam logic OpForward = 1'b0;
  localparam logic OpInsert  = 1'b1;

  localparam logic [1:0] ActDrop    = 2'd0;
  localparam logic [1:0] ActUnicast = 2'd1;
  localparam logic [1:0] ActFlood   = 2'd2;
  localparam logic [1:0] ActInsert  = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [PortW-1:0]  ingress_port;
    logic [MacW-1:0]   dest_mac;
    logic [MacW-1:0]   source_mac;
    logic [VlanW-1:0]  insert_vlan;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [PortW-1:0]  out_port;
    logic [NumPorts-1:0] flood_mask;
    logic              learn_request;
    logic              table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN1,
    ST_SCAN2,
    ST_WRITE,
    ST_OUT
  } state_t;

endpackage

@@ hdl/l2lb_stream_if.sv @@
// Valid/ready channel interface carrying one item of a given payload type.
// No dependencies; the payload type is a parameter.
interface l2lb_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/l2_learning_bridge_forwarder.sv @@
// Channel          | dir | payload
// in  (sink)       | in  | operation, ingress_port, dest_mac, source_mac, insert_vlan
// out (source)     | out | action, out_port, flood_mask, learn_request, table_full
// cfg_*            | in  | write enable, register index, 48-bit data
// Each table search reads one entry a cycle from the single RAM port. A frame with a
// unicast source takes two searches and a write step, an insert one search and a write
// step, a frame with a group source one search and a frame from an invalid port none.
// After reset a clearing pass zeroes all entries, valid bits included; no item is
// taken meanwhile. One item is in work at a time; a result blocks the input until taken.
// Depends on l2lb_pkg, l2lb_stream_if and l2lb_ram.
module l2_learning_bridge_forwarder (
  input  logic                       clk,
  input  logic                       rst_n,
  l2lb_stream_if.sink                in_if,
  l2lb_stream_if.source              out_if,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [l2lb_pkg::CfgW-1:0]  cfg_wdata
);

  localparam int IdxW = l2lb_pkg::IdxW;
  localparam int CntW = l2lb_pkg::CntW;
  localparam int NP   = l2lb_pkg::NumPorts;

  // Configuration registers
  logic [7:0]                  valid_mask_r;
  logic [l2lb_pkg::CfgW-1:0]   vlan_low_r, vlan_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_mask_r <= '0;
      vlan_low_r   <= '0;
      vlan_high_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        l2lb_pkg::CfgValidMask: valid_mask_r <= cfg_wdata[7:0];
        l2lb_pkg::CfgVlanLow:   vlan_low_r   <= cfg_wdata;
        l2lb_pkg::CfgVlanHigh:  vlan_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [l2lb_pkg::VlanW-1:0] vlan_of(
      input logic [2:0] p, input logic [47:0] lo, input logic [47:0] hi);
    logic [47:0] w;
    w = p[2] ? hi : lo;
    return w[12*p[1:0] +: 12];
  endfunction

  // Item and search state
  l2lb_pkg::state_t state_r, state_nxt;
  l2lb_pkg::in_item_t item_r;
  logic [CntW-1:0] idx_r, idx_nxt;       // entry whose read is issued
  logic            rd_vld_r;             // rdata belongs to idx_r-1
  logic [IdxW-1:0] rd_idx_r;
  logic            hit_r, free_found_r;
  logic [IdxW-1:0] hit_idx_r, free_idx_r;
  logic [l2lb_pkg::PortW-1:0] hit_port_r;
  l2lb_pkg::out_item_t res_r;
  logic            out_valid_r;
  logic [l2lb_pkg::VlanW-1:0] vlan_r;
  logic            port_ok_r;

  // RAM port
  logic                        ram_we;
  logic [IdxW-1:0]             ram_addr;
  logic [l2lb_pkg::EntryW-1:0] ram_wdata, ram_rdata;

  l2lb_ram #(.Width(l2lb_pkg::EntryW), .Depth(l2lb_pkg::TableDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic                        e_valid;
  logic [l2lb_pkg::KeyW-1:0]   e_key;
  logic [l2lb_pkg::PortW-1:0]  e_port;
  assign {e_valid, e_key, e_port} = ram_rdata;

  // Search key of the current scan
  logic [l2lb_pkg::KeyW-1:0] key1, key2;
  assign key1 = (item_r.operation == l2lb_pkg::OpInsert)
              ? {item_r.insert_vlan, item_r.source_mac}
              : {vlan_r, item_r.dest_mac};
  assign key2 = {vlan_r, item_r.source_mac};

  logic e_match1, e_match2;
  assign e_match1 = rd_vld_r && e_valid && (e_key == key1);
  assign e_match2 = rd_vld_r && e_valid && (e_key == key2);

  logic scan_done;
  assign scan_done = (idx_r == CntW'(l2lb_pkg::TableDepth)) && !rd_vld_r;

  // Flood set
  logic [7:0] vmask;
  logic [NP-1:0] flood_set;
  always_comb begin
    vmask = valid_mask_r & 8'(( 9'd1 << NP) - 9'd1);
    for (int p = 0; p < NP; p++) begin
      flood_set[p] = vmask[p] && (3'(p) != item_r.ingress_port)
                  && (vlan_of(3'(p), vlan_low_r, vlan_high_r) == vlan_r);
    end
  end

  assign in_if.ready   = (state_r == l2lb_pkg::ST_IDLE) && !out_valid_r;
  assign out_if.valid  = out_valid_r;
  assign out_if.data   = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      l2lb_pkg::ST_CLEAR:
        if (idx_r == CntW'(l2lb_pkg::TableDepth - 1)) state_nxt = l2lb_pkg::ST_IDLE;
      l2lb_pkg::ST_IDLE:
        if (in_if.valid && in_if.ready) begin
          state_nxt = l2lb_pkg::ST_SCAN1;
        end
      l2lb_pkg::ST_SCAN1:
        if (item_r.operation == l2lb_pkg::OpForward && !port_ok_r)
          state_nxt = l2lb_pkg::ST_OUT;
        else if (scan_done) begin
          if (item_r.operation == l2lb_pkg::OpInsert) state_nxt = l2lb_pkg::ST_WRITE;
          else if (item_r.source_mac[l2lb_pkg::GroupBit]) state_nxt = l2lb_pkg::ST_OUT;
          else state_nxt = l2lb_pkg::ST_SCAN2;
        end
      l2lb_pkg::ST_SCAN2:
        if (scan_done) state_nxt = l2lb_pkg::ST_WRITE;
      l2lb_pkg::ST_WRITE:
        state_nxt = l2lb_pkg::ST_OUT;
      l2lb_pkg::ST_OUT:
        state_nxt = l2lb_pkg::ST_IDLE;
      default:
        state_nxt = l2lb_pkg::ST_IDLE;
    endcase
  end

  // RAM access and index
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx_r[IdxW-1:0];
    ram_wdata = '0;
    idx_nxt   = idx_r;
    unique case (state_r)
      l2lb_pkg::ST_CLEAR: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      l2lb_pkg::ST_IDLE:
        idx_nxt = '0;
      l2lb_pkg::ST_SCAN1, l2lb_pkg::ST_SCAN2:
        if (scan_done) idx_nxt = '0;
        else if (idx_r != CntW'(l2lb_pkg::TableDepth)) idx_nxt = idx_r + 1'b1;
      l2lb_pkg::ST_WRITE:
        if (item_r.operation == l2lb_pkg::OpInsert) begin
          ram_we    = hit_r || free_found_r;
          ram_addr  = hit_r ? hit_idx_r : free_idx_r;
          ram_wdata = {1'b1, item_r.insert_vlan, item_r.source_mac,
                       item_r.ingress_port};
        end else begin
          ram_we    = hit_r;
          ram_addr  = hit_idx_r;
          ram_wdata = {1'b1, key2, item_r.ingress_port};
        end
      default: ;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= l2lb_pkg::ST_CLEAR;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= (state_r == l2lb_pkg::ST_SCAN1 || state_r == l2lb_pkg::ST_SCAN2)
                  && !scan_done && (idx_r != CntW'(l2lb_pkg::TableDepth));
      if (out_if.valid && out_if.ready) out_valid_r <= 1'b0;
      if (state_r == l2lb_pkg::ST_OUT) out_valid_r <= 1'b1;
    end
  end

  // Payload: item capture, scan results, result build
  always_ff @(posedge clk) begin
    rd_idx_r <= idx_r[IdxW-1:0];
    if (in_if.valid && in_if.ready) begin
      item_r       <= in_if.data;
      vlan_r       <= vlan_of(in_if.data.ingress_port, vlan_low_r, vlan_high_r);
      port_ok_r    <= vmask[in_if.data.ingress_port];
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      res_r        <= '0;
    end
    if (state_r == l2lb_pkg::ST_SCAN1) begin
      if (e_match1 && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= rd_idx_r;
        hit_port_r <= e_port;
      end
      if (rd_vld_r && !e_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
      if (scan_done) begin
        if (item_r.operation == l2lb_pkg::OpInsert) begin
          res_r.action     <= l2lb_pkg::ActInsert;
          res_r.table_full <= !hit_r && !free_found_r;
        end else begin
          if (hit_r && !item_r.dest_mac[l2lb_pkg::GroupBit]) begin
            res_r.action   <= l2lb_pkg::ActUnicast;
            res_r.out_port <= hit_port_r;
          end else if (flood_set != '0) begin
            res_r.action     <= l2lb_pkg::ActFlood;
            res_r.flood_mask <= flood_set;
          end
          hit_r <= 1'b0;
        end
      end
    end
    if (state_r == l2lb_pkg::ST_SCAN2) begin
      if (e_match2 && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (scan_done) res_r.learn_request <= !hit_r;
    end
  end

endmodule

@@ hdl/l2lb_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module l2lb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hdl/l2lb_checker.sv @@
// Port-level checks for the learning bridge forwarder, bound to the top level.
// Depends on l2lb_pkg and l2lb_stream_if.
module l2lb_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input l2lb_pkg::out_item_t out_data
);
  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  // One item in flight: no accept while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept with pending result");
  // Port and table_full exclusive with action
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != l2lb_pkg::ActUnicast |-> out_data.out_port == '0)
    else $error("out_port set without unicast");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != l2lb_pkg::ActInsert |-> !out_data.table_full)
    else $error("table_full on frame");
  // A result never appears right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind l2_learning_bridge_forwarder l2lb_checker u_l2lb_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
